// File: rtl/lagas_pkg.sv
// ---------------------------------------------------------------------------
// lagas_pkg: shared types and constants of the local alignment scorer
// Cell count, memory geometry, command codes and the issue and score-token
// structures passed between the sequencer and the cell chain.
// ---------------------------------------------------------------------------
package lagas_pkg;

  localparam int MAX_QUERY   = 1024;
  localparam int ALPHABET    = 32;
  localparam int NCELLS      = 16;
  localparam int CELL_BITS   = $clog2(NCELLS);
  localparam int ROW_BITS    = $clog2(MAX_QUERY);
  localparam int LEN_BITS    = ROW_BITS + 1;
  localparam int STRIP_DEPTH = MAX_QUERY / NCELLS;
  localparam int STRIP_BITS  = $clog2(STRIP_DEPTH);
  localparam int CODE_BITS   = $clog2(ALPHABET);
  localparam int SUB_BITS    = 2 * CODE_BITS;
  localparam int SCORE_BITS  = 20;
  localparam int GAP_BITS    = 21;
  localparam int WIDE_BITS   = 22;
  localparam int PEN_BITS    = 8;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

  localparam logic [1:0] CMD_MATRIX = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_DB     = 2'd2;

  localparam logic [1:0] REG_QUERY_LENGTH = 2'd0;
  localparam logic [1:0] REG_GAP_OPEN     = 2'd1;
  localparam logic [1:0] REG_GAP_EXTEND   = 2'd2;

  // one row handed to a cell by the sequencer
  typedef struct packed {
    logic                  en;
    logic                  first;
    logic                  valid;
    logic [STRIP_BITS-1:0] strip;
    logic [CODE_BITS-1:0]  dr;
  } issue_t;

  // value handed from one row's cell to the next row's cell
  typedef struct packed {
    logic signed [GAP_BITS-1:0] vgap;
    logic [SCORE_BITS-1:0]      diag;
    logic [SCORE_BITS-1:0]      best;
  } tok_t;

  typedef struct packed {
    logic [PEN_BITS-1:0] ext;
    logic [PEN_BITS:0]   oe;
  } gap_t;

endpackage

// File: rtl/local_alignment_affine_gap_scorer.sv
// ---------------------------------------------------------------------------
// local_alignment_affine_gap_scorer: Smith-Waterman score with affine gaps
// Loads a substitution matrix and a query, then scores database sequences.
// ---------------------------------------------------------------------------
// A chain of 16 cells holds the query; cell k owns rows k, k+16, k+32 and so
// on, each with its own residue memory, substitution table copy and H/F
// memories. A database residue (one transfer with command 2) walks its column
// down the query one row per cycle: the sequencer issues row r to cell r mod
// 16, and the vertical gap, diagonal and running best travel from cell to
// cell with the wavefront, wrapping from the last cell back to the first.
// A residue therefore keeps the input closed while the min(query_length,1024)
// rows of its column are issued, a pace set by the row-by-row dependency of
// the vertical gap, then while the cell pipeline drains and in a closing state.
// The residue that ends the sequence also stays in the closing state while
// an earlier best score still waits in the output register. An empty query
// skips the chain and goes straight to the closing state. Matrix and query
// writes, and any transfer with an unused command, leave the input open and
// can follow each other back to back. H and F of rows not yet touched since
// the last sequence end read as zero through a fill count, so no clearing
// pass is needed after reset. The best score leaves through an output
// register and waits there until taken; configuration is written by the user
// only while the block is idle, which the block itself does not enforce.
module local_alignment_affine_gap_scorer
  import lagas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [10:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [4:0]           matrix_row,
  input  logic [4:0]           matrix_col,
  input  logic signed [7:0]    matrix_value,
  input  logic [9:0]           query_position,
  input  logic [4:0]           query_residue,
  input  logic [4:0]           db_residue,
  input  logic                 db_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [19:0]          best_score
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]            state;
  logic [LEN_BITS-1:0]   query_length;
  logic [PEN_BITS-1:0]   gap_open, gap_extend;
  logic [SCORE_BITS-1:0] running_best;
  logic [LEN_BITS-1:0]   fill;      // rows holding live H/F since sequence start
  logic [LEN_BITS-1:0]   rows;
  logic [ROW_BITS-1:0]   row;
  logic [ROW_BITS-1:0]   last_row;
  logic [CODE_BITS-1:0]  dr;
  logic                  last;
  logic [1:0]            drain;
  logic                  accept, out_free;
  gap_t                  gap;
  issue_t                iss [NCELLS];
  tok_t                  tok [NCELLS];
  logic [LEN_BITS-1:0]   len_clip;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign gap.ext  = gap_extend;
  assign gap.oe   = {1'b0, gap_open} + {1'b0, gap_extend};
  assign len_clip = (query_length > LEN_BITS'(MAX_QUERY)) ? LEN_BITS'(MAX_QUERY)
                                                          : query_length;

  // broadcast the row address, enable only the owning cell
  always_comb begin
    for (int k = 0; k < NCELLS; k++) begin
      iss[k].en    = (state == S_RUN) && (row[CELL_BITS-1:0] == CELL_BITS'(k));
      iss[k].first = (row == '0);
      iss[k].valid = ({1'b0, row} < fill);
      iss[k].strip = row[ROW_BITS-1:CELL_BITS];
      iss[k].dr    = dr;
    end
  end

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    localparam int PREV = (k == 0) ? NCELLS - 1 : k - 1;
    lagas_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .iss         (iss[k]),
      .gap         (gap),
      .q_we        (accept && command == CMD_QUERY &&
                    query_position[CELL_BITS-1:0] == CELL_BITS'(k)),
      .q_addr      (query_position[ROW_BITS-1:CELL_BITS]),
      .q_data      (query_residue),
      .m_we        (accept && command == CMD_MATRIX),
      .m_addr      ({matrix_row, matrix_col}),
      .m_data      (matrix_value),
      .tok_in      (tok[PREV]),
      .launch_best (running_best),
      .tok_out     (tok[k])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= '0;
      gap_open     <= 8'd10;
      gap_extend   <= 8'd2;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_QUERY_LENGTH: query_length <= cfg_data;
        REG_GAP_OPEN:     gap_open     <= cfg_data[PEN_BITS-1:0];
        REG_GAP_EXTEND:   gap_extend   <= cfg_data[PEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: issue rows, drain the chain, fold the best, emit on last
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      running_best <= '0;
      fill         <= '0;
      row          <= '0;
      drain        <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && command == CMD_DB) begin
            dr   <= db_residue;
            last <= db_last;
            rows <= len_clip;
            row  <= '0;
            // hold the sequencer out of the chain for an empty query
            state <= (len_clip == '0) ? S_FIN : S_RUN;
          end
        end
        S_RUN: begin
          if ({1'b0, row} == rows - LEN_BITS'(1)) begin
            last_row <= row;
            drain    <= '0;
            state    <= S_DRAIN;
          end else begin
            row <= row + ROW_BITS'(1);
          end
        end
        S_DRAIN: begin
          drain <= drain + 2'd1;
          if (drain == 2'd2) begin
            running_best <= tok[last_row[CELL_BITS-1:0]].best;
            if (rows > fill) begin
              fill <= rows;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid    <= 1'b1;
            best_score   <= running_best;
            running_best <= '0;
            fill         <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/lagas_cell.sv
// ---------------------------------------------------------------------------
// lagas_cell: one cell of the scoring chain
// Owns every sixteenth query row: residue, substitution table copy, H and F.
// Three stages: residue read, table and state read, score update.
// ---------------------------------------------------------------------------
module lagas_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  lagas_pkg::issue_t                   iss,
  input  lagas_pkg::gap_t                     gap,
  input  logic                                q_we,
  input  logic [lagas_pkg::STRIP_BITS-1:0]    q_addr,
  input  logic [lagas_pkg::CODE_BITS-1:0]     q_data,
  input  logic                                m_we,
  input  logic [lagas_pkg::SUB_BITS-1:0]      m_addr,
  input  logic [7:0]                          m_data,
  input  lagas_pkg::tok_t                     tok_in,
  input  logic [lagas_pkg::SCORE_BITS-1:0]    launch_best,
  output lagas_pkg::tok_t                     tok_out
);
  import lagas_pkg::*;

  logic [CODE_BITS-1:0]      qmem [STRIP_DEPTH];
  logic [7:0]                smem [ALPHABET*ALPHABET];
  logic [SCORE_BITS-1:0]     hmem [STRIP_DEPTH];
  logic signed [GAP_BITS-1:0] fmem [STRIP_DEPTH];

  logic                  en1, first1, valid1;
  logic [STRIP_BITS-1:0] strip1;
  logic [CODE_BITS-1:0]  dr1, q1;

  logic                       en2, first2, valid2;
  logic [STRIP_BITS-1:0]      strip2;
  logic signed [7:0]          sub2;
  logic [SCORE_BITS-1:0]      hraw2;
  logic signed [GAP_BITS-1:0] fraw2;

  logic [SCORE_BITS-1:0]       h_old, diag_in, best_in, h;
  logic signed [GAP_BITS-1:0]  f_old, vg_in, f_new, vg_new;
  logic signed [WIDE_BITS-1:0] s, m, fa, fb, va, hb, f_w, v_w;

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_addr] <= q_data;
    end
    if (m_we) begin
      smem[m_addr] <= m_data;
    end
    if (iss.en) begin
      q1 <= qmem[iss.strip];
    end
    strip1 <= iss.strip;
    dr1    <= iss.dr;
    first1 <= iss.first;
    valid1 <= iss.valid;
    if (en1) begin
      sub2  <= smem[{q1, dr1}];
      hraw2 <= hmem[strip1];
      fraw2 <= fmem[strip1];
    end
    strip2 <= strip1;
    first2 <= first1;
    valid2 <= valid1;
    if (en2) begin
      hmem[strip2] <= h;
      fmem[strip2] <= f_new;
      tok_out      <= '{vgap: vg_new, diag: h_old, best: (h > best_in) ? h : best_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      en1 <= 1'b0;
      en2 <= 1'b0;
    end else begin
      en1 <= iss.en;
      en2 <= en1;
    end
  end

  always_comb begin
    // rows beyond the fill count read as cleared
    h_old   = valid2 ? hraw2 : '0;
    f_old   = valid2 ? fraw2 : '0;
    diag_in = first2 ? '0 : tok_in.diag;
    vg_in   = first2 ? '0 : tok_in.vgap;
    best_in = first2 ? launch_best : tok_in.best;
    s = $signed({2'b00, diag_in}) + WIDE_BITS'(sub2);
    m = s;
    if (WIDE_BITS'(f_old) > m) m = WIDE_BITS'(f_old);
    if (WIDE_BITS'(vg_in) > m) m = WIDE_BITS'(vg_in);
    if (m < 0) m = '0;
    h  = (m > $signed({2'b00, SCORE_MAX})) ? SCORE_MAX : m[SCORE_BITS-1:0];
    hb = $signed({2'b00, h}) - $signed({{(WIDE_BITS-PEN_BITS-1){1'b0}}, gap.oe});
    fa = WIDE_BITS'(f_old) - $signed({{(WIDE_BITS-PEN_BITS){1'b0}}, gap.ext});
    va = WIDE_BITS'(vg_in) - $signed({{(WIDE_BITS-PEN_BITS){1'b0}}, gap.ext});
    f_w = (fa > hb) ? fa : hb;
    v_w = (va > hb) ? va : hb;
    f_new  = f_w[GAP_BITS-1:0];
    vg_new = v_w[GAP_BITS-1:0];
  end

endmodule

// File: rtl/lagas_checker.sv
// ---------------------------------------------------------------------------
// lagas_checker: port-level checks of the local alignment scorer
// Watches the handshakes and the result timing; bound to the top level.
// ---------------------------------------------------------------------------
module lagas_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [19:0] best_score
);
  import lagas_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_score))
    else $error("result changed while stalled");

  // after reset the block is empty and ready
  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // a result never appears the cycle after an input transfer
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early after transfer");

  // the input closes once a database residue is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_DB |=> !in_ready)
    else $error("input taken during work");

endmodule

bind local_alignment_affine_gap_scorer lagas_checker u_lagas_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .command    (command),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .best_score (best_score)
);
